// ===== rtl/spiral_layer_bit_placer_unit_macros.svh =====
// Assertion helpers for the spiral layer bit placer.
// Both macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef SPIRAL_LAYER_BIT_PLACER_UNIT_MACROS_SVH
`define SPIRAL_LAYER_BIT_PLACER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLBP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slbp_pkg;

  // Width of the signed coordinates on the result word.
  localparam int COORD_BITS = 8;

  // Largest layer height the spiral may reach.
  localparam logic [7:0] MAX_HEIGHT = 8'd255;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEIGHT = 1'b1;

  // Side numbers of a layer.
  localparam logic [1:0] SIDE_DIRECT  = 2'd0;
  localparam logic [1:0] SIDE_SWAP_R  = 2'd1;
  localparam logic [1:0] SIDE_NEG_ALL = 2'd2;
  localparam logic [1:0] SIDE_SWAP_C  = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic data_bit;
    logic end_of_symbol;
  } slbp_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] col;
    logic signed [COORD_BITS-1:0] row;
    logic                         module_bit;
    logic                         final_res;
    logic                         overflow;
  } slbp_out_t;

  // Walk position within the spiral.
  typedef struct packed {
    logic [7:0] layer_height;
    logic [1:0] side_index;
    logic [7:0] along_count;
    logic [3:0] across_count;
    logic       overflowed;
    logic       start_pending;
  } slbp_state_t;

endpackage

`default_nettype wire

// ===== rtl/spiral_layer_bit_placer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Spiral layer bit placer.
// Each input word carries one data bit and an end-of-symbol mark. The block
// answers with one result word: the signed column and row, relative to the
// symbol center, where the bit lands in a clockwise square spiral of layers,
// the bit itself, the end mark and an overflow flag for a spiral that has
// grown past a height of 255 (coordinates then read as zero).
// A word accepted at one edge is offered on the result channel in the next
// cycle. Throughput is one word per cycle while the receiver takes every result;
// the walk position is updated by a single pass of logic, and one result
// register separates the two channels. When the receiver stalls, the result
// holds and in_ready falls until the held word is taken; a new word is
// accepted in the same cycle as the held word leaves.
// Configuration (layer width, first height) is written through the cfg port,
// which is always ready, and is meant to change only while the block is idle.
// Reset empties the result register, sets the width to 2 and the first height
// to 15, and arms a spiral start for the first word.
module spiral_layer_bit_placer_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  slbp_pkg::slbp_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output slbp_pkg::slbp_out_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [slbp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [slbp_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import slbp_pkg::*;

  logic [3:0]  ring_width_r;
  logic [7:0]  first_height_r;
  slbp_state_t state_r;
  slbp_state_t state_nxt;
  slbp_out_t   result_nxt;
  slbp_out_t   out_data_r;
  logic        out_valid_r;
  logic        in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_width_r   <= 4'd2;
      first_height_r <= 8'd15;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RING_WIDTH:   ring_width_r   <= cfg_data[3:0];
        CFG_FIRST_HEIGHT: first_height_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  slbp_step u_step (
    .cur          (state_r),
    .ring_width   (ring_width_r),
    .first_height (first_height_r),
    .item         (in_data),
    .nxt          (state_nxt),
    .result       (result_nxt)
  );

  // Walk position advances once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.layer_height  <= 8'd0;
      state_r.side_index    <= SIDE_DIRECT;
      state_r.along_count   <= 8'd0;
      state_r.across_count  <= 4'd0;
      state_r.overflowed    <= 1'b0;
      state_r.start_pending <= 1'b1;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= result_nxt;
    end
  end

`include "spiral_layer_bit_placer_unit_macros.svh"

  `SLBP_ASSERT_NEXT(a_result_follows, in_fire, out_valid, "accepted word gave no result")
  `SLBP_ASSERT_SAME(a_ovf_zero_pos, out_valid && out_data.overflow, (out_data.col == '0) && (out_data.row == '0), "overflow result with nonzero position")
  `SLBP_ASSERT_NEXT(a_eos_rearms, in_fire && in_data.end_of_symbol, state_r.start_pending, "end of symbol did not arm a restart")

endmodule

`default_nettype wire

// ===== rtl/slbp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Placement of one word: computes its coordinates from the current walk
// position and the next walk position.
module slbp_step (
  input  slbp_pkg::slbp_state_t cur,
  input  logic [3:0]            ring_width,
  input  logic [7:0]            first_height,
  input  slbp_pkg::slbp_in_t    item,
  output slbp_pkg::slbp_state_t nxt,
  output slbp_pkg::slbp_out_t   result
);
  import slbp_pkg::*;

  logic [3:0] w;
  logic [7:0] w8;
  logic [7:0] h;
  logic [1:0] side;
  logic [7:0] along;
  logic [3:0] across;
  logic       ovf;
  logic [8:0] grow_a;
  logic [8:0] grow_b;
  logic [8:0] grow_c;
  logic [7:0] half;
  logic       e;
  logic [7:0] len;
  logic [8:0] along_inc;
  logic [4:0] across_inc;
  coord_t     x;
  coord_t     y;
  coord_t     col;
  coord_t     row;
  coord_t     pos_ovf;

  always_comb begin
    // A zero width behaves as a width of one.
    w  = (ring_width == 4'd0) ? 4'd1 : ring_width;
    w8 = {4'b0, w};

    h      = cur.layer_height;
    side   = cur.side_index;
    along  = cur.along_count;
    across = cur.across_count;
    ovf    = cur.overflowed;

    // Spiral start loads the first height and clears the walk.
    if (cur.start_pending) begin
      h      = first_height;
      side   = SIDE_DIRECT;
      along  = 8'd0;
      across = 4'd0;
      ovf    = 1'b0;
    end

    // A layer thinner than the width holds nothing and is skipped.
    grow_a = {1'b0, h} + {4'b0, w, 1'b0};
    if (!ovf && (h < w8)) begin
      if (grow_a > {1'b0, MAX_HEIGHT}) begin
        ovf = 1'b1;
      end else begin
        h = grow_a[7:0];
      end
      side   = SIDE_DIRECT;
      along  = 8'd0;
      across = 4'd0;
    end

    result.overflow = ovf;
    col = '0;
    row = '0;

    half       = h >> 1;
    e          = ~h[0];
    len        = h - w8;
    along_inc  = {1'b0, along} + 9'd1;
    across_inc = {1'b0, across} + 5'd1;
    grow_b     = {1'b0, h} + {4'b0, w, 1'b0};
    grow_c     = grow_b;

    x = coord_t'(w) - coord_t'(half) + coord_t'(along);
    y = coord_t'(h) - coord_t'(half) - coord_t'(w) + coord_t'(across);
    pos_ovf = coord_t'(e);

    if (!ovf) begin
      if (h == w8) begin
        // Single centre module: placed at the origin, then the next layer.
        if (grow_c > {1'b0, MAX_HEIGHT}) begin
          ovf = 1'b1;
        end else begin
          h = grow_c[7:0];
        end
        side   = SIDE_DIRECT;
        along  = 8'd0;
        across = 4'd0;
      end else begin
        // Map the side-0 position onto the current side.
        unique case (side)
          SIDE_DIRECT: begin
            col = x;
            row = y;
          end
          SIDE_SWAP_R: begin
            col = y;
            row = '0 - (x + pos_ovf);
          end
          SIDE_NEG_ALL: begin
            col = '0 - (x + pos_ovf);
            row = '0 - (y + pos_ovf);
          end
          SIDE_SWAP_C: begin
            col = '0 - (y + pos_ovf);
            row = x;
          end
          default: begin
            col = x;
            row = y;
          end
        endcase

        // Step across the thickness, then along the side, then to the next side.
        if (across_inc >= {1'b0, w}) begin
          across = 4'd0;
          if (along_inc >= {1'b0, len}) begin
            along = 8'd0;
            if (side == SIDE_SWAP_C) begin
              if (grow_b > {1'b0, MAX_HEIGHT}) begin
                ovf = 1'b1;
              end else begin
                h = grow_b[7:0];
              end
              side = SIDE_DIRECT;
            end else begin
              side = side + 2'd1;
            end
          end else begin
            along = along_inc[7:0];
          end
        end else begin
          across = across_inc[3:0];
        end
      end
    end

    result.col        = col;
    result.row        = row;
    result.module_bit = item.data_bit;
    result.final_res  = item.end_of_symbol;

    nxt.layer_height  = h;
    nxt.side_index    = side;
    nxt.along_count   = along;
    nxt.across_count  = across;
    nxt.overflowed    = ovf;
    nxt.start_pending = item.end_of_symbol;
  end

endmodule

`default_nettype wire

// ===== dv/spiral_layer_bit_placer_unit_tb.sv =====
`timescale 1ns / 1ps

module spiral_layer_bit_placer_unit_tb;
  import slbp_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_WORDS     = 1800;
  localparam int SPIRAL_RUN_WORDS = 1030;
  localparam int MAX_PRINTED      = 40;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic [CFG_IDX_W-1:0]      reg_index;
    logic [CFG_DATA_W-1:0]     reg_data;
    slbp_in_t                  word;
    bit                        pinned;
    slbp_out_t                 pin_res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  slbp_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  slbp_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the registers and of the walk position.
  logic [3:0] width_reg        = 4'd2;
  logic [7:0] first_height_reg = 8'd15;
  logic [7:0] lay_height       = 8'd0;
  logic [1:0] lay_side         = SIDE_DIRECT;
  logic [7:0] lay_along        = 8'd0;
  logic [3:0] lay_across       = 4'd0;
  logic       lay_overflowed   = 1'b0;
  logic       restart_armed    = 1'b1;

  slbp_out_t placement_q[$];
  stim_row_t plan_q[$];

  bit        pin_on      = 1'b0;
  slbp_out_t pin_word    = '0;
  bit        in_idle_on  = 1'b1;
  bit        out_idle_on = 1'b1;
  int        fail_count  = 0;
  int        result_count = 0;
  int        cycle_count = 0;

  spiral_layer_bit_placer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The run is cut off if it takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                result_count, name, got, want));
    end
  endtask

  // Moving out to the next layer; past the largest height the spiral is marked overflowed.
  function automatic void widen_spiral(input int wd);
    int next_h;
    next_h = int'(lay_height) + 2 * wd;
    if (next_h > int'(MAX_HEIGHT)) begin
      lay_overflowed = 1'b1;
    end else begin
      lay_height = next_h[7:0];
    end
    lay_side   = SIDE_DIRECT;
    lay_along  = 8'd0;
    lay_across = 4'd0;
  endfunction

  // Works out where one bit lands and advances the walk position.
  function automatic slbp_out_t place_bit(input slbp_in_t w);
    slbp_out_t r;
    int        wd;
    int        h;
    int        half;
    int        e;
    int        x;
    int        y;
    int        t;
    int        len;
    int        nxt;
    logic      ovf;
    wd = (width_reg == 4'd0) ? 1 : int'(width_reg);
    x  = 0;
    y  = 0;
    if (restart_armed) begin
      lay_height     = first_height_reg;
      lay_side       = SIDE_DIRECT;
      lay_along      = 8'd0;
      lay_across     = 4'd0;
      lay_overflowed = 1'b0;
      restart_armed  = 1'b0;
    end
    // A layer thinner than the width holds nothing and is skipped.
    if (!lay_overflowed && int'(lay_height) < wd) begin
      widen_spiral(wd);
    end
    ovf = lay_overflowed;
    if (!ovf) begin
      if (int'(lay_height) == wd) begin
        // The single center module sits at the origin.
        widen_spiral(wd);
      end else begin
        h    = int'(lay_height);
        half = h / 2;
        e    = (h % 2 == 0) ? 1 : 0;
        x    = wd - half + int'(lay_along);
        y    = h - half - wd + int'(lay_across);
        case (lay_side)
          SIDE_SWAP_R: begin
            t = x;
            x = y;
            y = -(t + e);
          end
          SIDE_NEG_ALL: begin
            x = -(x + e);
            y = -(y + e);
          end
          SIDE_SWAP_C: begin
            t = x;
            x = -(y + e);
            y = t;
          end
          default: ;
        endcase
        // Step across the thickness first, then along the side, then to the next side.
        len = h - wd;
        nxt = int'(lay_across) + 1;
        if (nxt >= wd) begin
          lay_across = 4'd0;
          nxt = int'(lay_along) + 1;
          if (nxt >= len) begin
            lay_along = 8'd0;
            if (lay_side == SIDE_SWAP_C) begin
              widen_spiral(wd);
            end else begin
              lay_side = lay_side + 2'd1;
            end
          end else begin
            lay_along = nxt[7:0];
          end
        end else begin
          lay_across = nxt[3:0];
        end
      end
    end
    r.col        = x[COORD_BITS-1:0];
    r.row        = y[COORD_BITS-1:0];
    r.module_bit = w.data_bit;
    r.final_res  = w.end_of_symbol;
    r.overflow   = ovf;
    if (w.end_of_symbol) begin
      restart_armed = 1'b1;
    end
    return r;
  endfunction

  // Everything is sampled at the rising edge: results are checked, accepted words
  // are predicted, and register writes update the shadow copy.
  always @(posedge clk) begin : watch
    slbp_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (placement_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", out_data));
        end else begin
          want = placement_q.pop_front();
          compare_field("col", int'(out_data.col), int'(want.col));
          compare_field("row", int'(out_data.row), int'(want.row));
          compare_field("module_bit", int'(out_data.module_bit), int'(want.module_bit));
          compare_field("final_res", int'(out_data.final_res), int'(want.final_res));
          compare_field("overflow", int'(out_data.overflow), int'(want.overflow));
        end
        result_count++;
      end
      if (in_valid && in_ready) begin
        want = place_bit(in_data);
        if (pin_on) begin
          want.col      = pin_word.col;
          want.row      = pin_word.row;
          want.overflow = pin_word.overflow;
          pin_on        = 1'b0;
        end
        placement_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RING_WIDTH:   width_reg = cfg_data[3:0];
          CFG_FIRST_HEIGHT: first_height_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result side: a random stall before each word, none while idling is off.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Offers one input word after a random gap and holds it until it is taken.
  task automatic send_word(input slbp_in_t w, input bit pinned, input slbp_out_t pin_res);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pin_on   = pinned;
    pin_word = pin_res;
    in_data  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (placement_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic void add_word(input bit db, input bit eos, input bit pinned,
                                   input int pc, input int pr);
    stim_row_t row;
    row.kind                 = ROW_WORD;
    row.reg_index            = '0;
    row.reg_data             = '0;
    row.word.data_bit        = db;
    row.word.end_of_symbol   = eos;
    row.pinned               = pinned;
    row.pin_res              = '0;
    row.pin_res.col          = pc[COORD_BITS-1:0];
    row.pin_res.row          = pr[COORD_BITS-1:0];
    plan_q.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind      = ROW_REG;
    row.reg_index = idx;
    row.reg_data  = val;
    row.word      = '0;
    row.pinned    = 1'b0;
    row.pin_res   = '0;
    plan_q.push_back(row);
  endfunction

  initial begin : stimulus
    slbp_in_t              w;
    logic [CFG_DATA_W-1:0] val;
    int                    sent;
    int                    phase;
    int                    run_len;
    int                    eos_odds;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: width 2, first height 15, odd layer.
    add_word(1'b1, 1'b0, 1'b1, -5, 6);
    add_word(1'b0, 1'b0, 1'b1, -5, 7);
    add_word(1'b1, 1'b1, 1'b0, 0, 0);
    // Height equal to the width starts with the center module.
    add_reg(CFG_RING_WIDTH, 8'h01);
    add_reg(CFG_FIRST_HEIGHT, 8'h01);
    add_word(1'b0, 1'b0, 1'b1, 0, 0);
    add_word(1'b1, 1'b0, 1'b1, 0, 1);
    add_word(1'b1, 1'b1, 1'b0, 0, 0);
    // Widest layer at the largest height; the upper data bits of the width are ignored.
    add_reg(CFG_RING_WIDTH, 8'hFF);
    add_reg(CFG_FIRST_HEIGHT, 8'hFF);
    add_word(1'b1, 1'b0, 1'b1, -112, 113);
    add_word(1'b0, 1'b1, 1'b0, 0, 0);
    // A width of zero acts as one.
    add_reg(CFG_RING_WIDTH, 8'h00);
    add_word(1'b1, 1'b0, 1'b1, -126, 127);
    add_word(1'b0, 1'b1, 1'b0, 0, 0);
    // First height below the width: the layer is skipped, giving an even height.
    add_reg(CFG_RING_WIDTH, 8'h04);
    add_reg(CFG_FIRST_HEIGHT, 8'h02);
    add_word(1'b1, 1'b0, 1'b1, -1, 1);
    add_word(1'b0, 1'b0, 1'b0, 0, 0);
    add_word(1'b1, 1'b1, 1'b0, 0, 0);
    add_reg(CFG_FIRST_HEIGHT, 8'h00);
    add_word(1'b1, 1'b0, 1'b0, 0, 0);
    add_word(1'b0, 1'b1, 1'b0, 0, 0);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_REG) begin
        drain_results();
        write_reg(plan_q[i].reg_index, plan_q[i].reg_data);
      end else begin
        send_word(plan_q[i].word, plan_q[i].pinned, plan_q[i].pin_res);
      end
    end

    // Random phases, each separated by a full drain so registers change while idle.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // One long symbol at width one from height 254 or 255 runs into overflow.
        w = slbp_in_t'($urandom);
        w.end_of_symbol = 1'b1;
        send_word(w, 1'b0, '0);
        drain_results();
        write_reg(CFG_RING_WIDTH, {4'($urandom), 4'h1});
        write_reg(CFG_FIRST_HEIGHT, 8'(254 + $urandom_range(0, 1)));
        repeat (SPIRAL_RUN_WORDS) begin
          w = slbp_in_t'($urandom);
          w.end_of_symbol = 1'b0;
          send_word(w, 1'b0, '0);
        end
        w.end_of_symbol = 1'b1;
        send_word(w, 1'b0, '0);
        sent += SPIRAL_RUN_WORDS + 2;
      end else begin
        drain_results();
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 3))
            0:       val = {4'($urandom), 4'h0};
            1:       val = {4'($urandom), 4'hF};
            2:       val = {4'($urandom), 4'h1};
            default: val = 8'($urandom);
          endcase
          write_reg(CFG_RING_WIDTH, val);
        end
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 4))
            0:       val = 8'h00;
            1:       val = 8'hFF;
            2:       val = 8'($urandom);
            default: val = 8'($urandom_range(1, 40));
          endcase
          write_reg(CFG_FIRST_HEIGHT, val);
        end
        // Mostly long symbols so the walk reaches later sides and layers.
        run_len  = $urandom_range(20, 120);
        eos_odds = ($urandom_range(0, 2) == 0) ? 4 : 80;
        repeat (run_len) begin
          w = slbp_in_t'($urandom);
          w.end_of_symbol = ($urandom_range(1, eos_odds) == 1);
          send_word(w, 1'b0, '0);
        end
        sent += run_len;
      end
      phase++;
    end

    drain_results();
    repeat (3) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
